// File: design/ich_pkg.sv
// ----------------------------------------------------------------------------
// ich_pkg: shared types and constants for the internet checksum block
// Mode codes, protocol numbers and the word record passed from front to back.
// ----------------------------------------------------------------------------
package ich_pkg;

   localparam int WORD_W = 16;

   // packet kinds
   localparam logic [1:0] MODE_IPV4 = 2'd0;
   localparam logic [1:0] MODE_TCP  = 2'd1;
   localparam logic [1:0] MODE_UDP  = 2'd2;

   // pseudo header protocol numbers
   localparam logic [WORD_W-1:0] PROTO_TCP = 16'd6;
   localparam logic [WORD_W-1:0] PROTO_UDP = 16'd17;

   // word position of the udp checksum field
   localparam logic [2:0] UDP_CSUM_INDEX = 3'd3;
   localparam logic [2:0] INDEX_MAX      = 3'd7;

   localparam logic [WORD_W-1:0] HIGH_BYTE_MASK = 16'hFF00;
   localparam logic [WORD_W-1:0] ALL_ONES       = 16'hFFFF;
   localparam logic [WORD_W-1:0] ALL_ZEROS      = 16'h0000;

   // classified word, front to back
   typedef struct packed {
      logic [WORD_W-1:0] word;     // masked data word
      logic [WORD_W-1:0] pseudo;   // folded pseudo header sum, used on first
      logic              first;
      logic              last;
      logic              udp;      // packet is udp
   } item_type;

endpackage

// File: design/ich_front.sv
// ----------------------------------------------------------------------------
// ich_front: input classification
// Tracks word position and packet mode, masks the data word and folds the
// pseudo header into one 16-bit word on the first word of a packet.
// ----------------------------------------------------------------------------
module ich_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [1:0]                mode,
   input  logic                      first,
   input  logic                      last,
   input  logic [ich_pkg::WORD_W-1:0] data_word,
   input  logic [1:0]                byte_count,
   input  logic [31:0]               src_addr,
   input  logic [31:0]               dst_addr,
   input  logic [ich_pkg::WORD_W-1:0] seg_length,
   output ich_pkg::item_type         item
);
   import ich_pkg::*;

   logic [2:0]        index_ff, index_in;
   logic [1:0]        mode_ff, mode_in;
   logic [2:0]        cur_index;
   logic              pseudo_on;
   logic [18:0]       pseudo_raw;
   logic [16:0]       pseudo_f1;
   logic [WORD_W-1:0] pseudo_f2;
   logic [WORD_W-1:0] proto;
   logic [WORD_W-1:0] word_m;

   // effective position and mode for this word
   always_comb begin
      cur_index = first ? 3'd0 : index_ff;
      mode_in   = first ? mode : mode_ff;
      index_in  = last ? 3'd0 : ((cur_index == INDEX_MAX) ? INDEX_MAX : cur_index + 3'd1);
   end

   // pad a one-byte word, zero the udp checksum field
   always_comb begin
      word_m = (byte_count == 2'd1) ? (data_word & HIGH_BYTE_MASK) : data_word;
      if (mode_in == MODE_UDP && cur_index == UDP_CSUM_INDEX) begin
         word_m = ALL_ZEROS;
      end
   end

   // pseudo header sum, folded twice with end-around carry
   always_comb begin
      pseudo_on  = first && (mode == MODE_TCP || mode == MODE_UDP);
      proto      = (mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP;
      pseudo_raw = 19'(src_addr[31:16]) + 19'(src_addr[15:0])
                 + 19'(dst_addr[31:16]) + 19'(dst_addr[15:0])
                 + 19'(proto) + 19'(seg_length);
      pseudo_f1  = 17'(pseudo_raw[15:0]) + 17'(pseudo_raw[18:16]);
      pseudo_f2  = pseudo_f1[15:0] + 16'(pseudo_f1[16]);
   end

   always_comb begin
      item.word   = word_m;
      item.pseudo = pseudo_on ? pseudo_f2 : ALL_ZEROS;
      item.first  = first;
      item.last   = last;
      item.udp    = (mode_in == MODE_UDP);
   end

   // packet position and latched mode
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 3'd0;
         mode_ff  <= MODE_IPV4;
      end else if (accept) begin
         index_ff <= index_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

// File: design/ich_queue.sv
// ----------------------------------------------------------------------------
// ich_queue: two-entry queue between front and back
// Full rate with push and pop in the same cycle.
// ----------------------------------------------------------------------------
module ich_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ich_pkg::item_type push_item,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output ich_pkg::item_type head_item
);
   import ich_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// File: design/ich_back.sv
// ----------------------------------------------------------------------------
// ich_back: one's-complement accumulator and result register
// Adds one word per cycle with end-around carry, unless a last word waits on
// a held result, and registers the checksum of a packet on its last word.
// ----------------------------------------------------------------------------
module ich_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  ich_pkg::item_type          in_item,
   output logic                       in_pop,
   output logic                       out_valid,
   output logic [ich_pkg::WORD_W-1:0] out_checksum,
   input  logic                       out_ready
);
   import ich_pkg::*;

   logic [WORD_W-1:0] sum_ff, sum_in;
   logic              valid_ff;
   logic [WORD_W-1:0] csum_ff, csum_in;
   logic [WORD_W-1:0] base;
   logic [WORD_W:0]   raw;
   logic [WORD_W-1:0] folded;

   // a word without a result never waits on the output
   assign in_pop = in_valid && (!in_item.last || !valid_ff || out_ready);

   // end-around carry add
   always_comb begin
      base    = in_item.first ? in_item.pseudo : sum_ff;
      raw     = {1'b0, base} + {1'b0, in_item.word};
      folded  = raw[WORD_W-1:0] + WORD_W'(raw[WORD_W]);
      sum_in  = in_item.last ? ALL_ZEROS : folded;
      csum_in = ~folded;
      if (in_item.udp && csum_in == ALL_ZEROS) begin
         csum_in = ALL_ONES;
      end
   end

   // running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= ALL_ZEROS;
      end else if (in_pop) begin
         sum_ff <= sum_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_pop && in_item.last) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop && in_item.last) begin
         csum_ff <= csum_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_checksum = csum_ff;

endmodule

// File: design/internet_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header: streaming internet checksum
// One's-complement checksum over 16-bit packet words, with optional TCP or
// UDP pseudo header.
//
// Usage: packet words enter on the req_ channel, one per transaction; the
// word flagged first (tuser bit 2) restarts the sum and latches the mode,
// and for TCP or UDP folds the addresses, protocol and length into the
// starting sum. The word with req_tlast high closes the packet and yields
// one checksum transaction on the rsp_ channel.
// Throughput: one word per cycle, set by the single end-around-carry adder
// in the back end, unless a last word waits on a checksum not yet taken.
// A checksum is shown once its last word has been written into the queue at
// acceptance and the back end has added it into the result register.
// Reset clears the running sum, word position, latched mode, queue and
// result register. When the receiver stalls, the checksum holds in its
// register, the back end keeps adding words that bring no result, and the
// two-entry queue fills before req_tready falls.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // data_word[15:0], byte_count[17:16], src_addr[49:18],
   // dst_addr[81:50], seg_length[97:82], zero fill[103:98]
   input  logic [103:0]  req_tdata,
   // mode[1:0], first[2]
   input  logic [2:0]    req_tuser,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // checksum[15:0]
   output logic [15:0]   rsp_tdata
);
   import ich_pkg::*;

   item_type front_item;
   item_type head_item;
   logic     q_not_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     req_accept;

   assign req_tready = q_not_full;
   assign req_accept = req_tvalid && q_not_full;

   // classify incoming words
   ich_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .mode       (req_tuser[1:0]),
      .first      (req_tuser[2]),
      .last       (req_tlast),
      .data_word  (req_tdata[15:0]),
      .byte_count (req_tdata[17:16]),
      .src_addr   (req_tdata[49:18]),
      .dst_addr   (req_tdata[81:50]),
      .seg_length (req_tdata[97:82]),
      .item       (front_item)
   );

   // decoupling queue
   ich_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // accumulate and emit
   ich_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_not_empty),
      .in_item      (head_item),
      .in_pop       (q_pop),
      .out_valid    (rsp_tvalid),
      .out_checksum (rsp_tdata),
      .out_ready    (rsp_tready)
   );

endmodule

// File: tb/checksum_checker.sv
// ----------------------------------------------------------------------------
// checksum_checker: watches both channels of the internet checksum block
// Keeps its own running one's-complement sum, word position and latched
// mode, predicts the checksum of every closed packet and compares it with
// the transactions that leave on the rsp_ channel, oldest first.
// ----------------------------------------------------------------------------
module checksum_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   // data_word[15:0], byte_count[17:16], src_addr[49:18],
   // dst_addr[81:50], seg_length[97:82], zero fill[103:98]
   input  logic [103:0]  req_tdata,
   // mode[1:0], first[2]
   input  logic [2:0]    req_tuser,
   input  logic          req_tlast,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   // checksum[15:0]
   input  logic [15:0]   rsp_tdata,
   output int            mismatches,
   output int            pending,
   output int            compared
);
   import ich_pkg::*;

   // predicted packet state
   logic [WORD_W-1:0] sum_acc;
   logic [2:0]        word_pos;
   logic [1:0]        latched_mode;

   // checksums still owed by the block
   logic [WORD_W-1:0] owed_checksums[$];
   int                error_count;
   int                compare_count;

   // one's-complement add with end-around carry
   function automatic logic [WORD_W-1:0] ones_add(logic [WORD_W-1:0] acc,
                                                  logic [WORD_W-1:0] value);
      logic [WORD_W:0] total;
      total = {1'b0, acc} + {1'b0, value};
      return total[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, total[WORD_W]};
   endfunction

   initial begin
      sum_acc       = ALL_ZEROS;
      word_pos      = 3'd0;
      latched_mode  = MODE_IPV4;
      error_count   = 0;
      compare_count = 0;
      mismatches    = 0;
      pending       = 0;
      compared      = 0;
   end

   always @(posedge clock) begin
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] seg_len;
      logic [WORD_W-1:0] proto;
      logic [WORD_W-1:0] csum;
      logic [WORD_W-1:0] owed;
      logic [31:0]       src;
      logic [31:0]       dst;
      logic [1:0]        byte_cnt;
      logic [1:0]        mode;
      if (reset) begin
         sum_acc      = ALL_ZEROS;
         word_pos     = 3'd0;
         latched_mode = MODE_IPV4;
         owed_checksums.delete();
      end else begin
         // result transaction: compare with the oldest owed checksum
         if (rsp_tvalid && rsp_tready) begin
            if (owed_checksums.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected checksum %h with nothing owed", rsp_tdata);
            end else begin
               owed = owed_checksums.pop_front();
               compare_count++;
               if (rsp_tdata !== owed) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("checksum mismatch: expected %h, got %h", owed, rsp_tdata);
               end
            end
         end

         // word transaction: advance the predicted sum
         if (req_tvalid && req_tready) begin
            word     = req_tdata[15:0];
            byte_cnt = req_tdata[17:16];
            src      = req_tdata[49:18];
            dst      = req_tdata[81:50];
            seg_len  = req_tdata[97:82];
            mode     = req_tuser[1:0];

            // first word restarts and seeds the pseudo header
            if (req_tuser[2]) begin
               latched_mode = mode;
               sum_acc      = ALL_ZEROS;
               word_pos     = 3'd0;
               if (mode == MODE_TCP || mode == MODE_UDP) begin
                  proto   = (mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP;
                  sum_acc = ones_add(sum_acc, src[31:16]);
                  sum_acc = ones_add(sum_acc, src[15:0]);
                  sum_acc = ones_add(sum_acc, dst[31:16]);
                  sum_acc = ones_add(sum_acc, dst[15:0]);
                  sum_acc = ones_add(sum_acc, proto);
                  sum_acc = ones_add(sum_acc, seg_len);
               end
            end

            // odd byte pad and the udp checksum field
            if (byte_cnt == 2'd1)
               word = word & HIGH_BYTE_MASK;
            if (latched_mode == MODE_UDP && word_pos == UDP_CSUM_INDEX)
               word = ALL_ZEROS;

            sum_acc = ones_add(sum_acc, word);
            if (word_pos < INDEX_MAX)
               word_pos = word_pos + 3'd1;

            // last word closes the packet
            if (req_tlast) begin
               csum = ~sum_acc;
               if (latched_mode == MODE_UDP && csum == ALL_ZEROS)
                  csum = ALL_ONES;
               owed_checksums.push_back(csum);
               sum_acc  = ALL_ZEROS;
               word_pos = 3'd0;
            end
         end
      end
      mismatches <= error_count;
      compared   <= compare_count;
      pending    <= owed_checksums.size();
   end

endmodule

// File: tb/tb_internet_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// tb_internet_checksum_pseudo_header: testbench top for the checksum block
// Drives packets of 16-bit words in ipv4, tcp, udp and the unused mode,
// first a directed set of corner cases, then random packets with broken
// framing mixed in, under four pacing phases; the checker predicts and
// compares every checksum and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_internet_checksum_pseudo_header;
   import ich_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         WORDS_PER_PHASE = 412;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata  = '0;
   logic [2:0]    req_tuser  = '0;
   logic          req_tlast  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;

   int            mismatches;
   int            pending;
   int            compared;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            words_sent = 0;
   int            packets_closed = 0;

   always #4 clock = ~clock;

   internet_checksum_pseudo_header u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   checksum_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending),
      .compared   (compared)
   );

   // receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // one word transaction, with random sender gaps ahead of it
   task automatic send_word(input logic [1:0] mode, input logic first_word,
                            input logic last_word, input logic [15:0] word,
                            input logic [1:0] byte_cnt, input logic [31:0] src,
                            input logic [31:0] dst, input logic [15:0] seg_len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, seg_len, dst, src, byte_cnt, word};
      req_tuser  <= {first_word, mode};
      req_tlast  <= last_word;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
      if (last_word)
         packets_closed++;
   endtask

   // random 16-bit value leaning toward the extremes
   function automatic logic [15:0] pick_half();
      case ($urandom_range(9))
         0:       return ALL_ZEROS;
         1:       return ALL_ONES;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed packets, some headless, unterminated or restarted
   task automatic send_random_packet();
      int          count;
      int          restart_pos;
      int          roll;
      logic [1:0]  mode;
      logic [1:0]  byte_cnt;
      logic        drop_first;
      logic        drop_last;
      logic        first_word;
      logic        last_word;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] seg_len;
      count       = ($urandom_range(99) < 12) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      mode        = ($urandom_range(19) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
      drop_first  = ($urandom_range(9) == 0);
      drop_last   = ($urandom_range(19) == 0);
      restart_pos = ($urandom_range(19) == 0) ? $urandom_range(count - 1) : -1;
      src         = pick_addr();
      dst         = pick_addr();
      seg_len     = pick_half();
      for (int i = 0; i < count; i++) begin
         first_word = ((i == 0) && !drop_first) || (i == restart_pos);
         last_word  = (i == count - 1) && !drop_last;
         roll       = $urandom_range(99);
         if (roll < 3)
            byte_cnt = 2'd1;
         else if (roll < 5)
            byte_cnt = 2'd0;
         else if (roll < 7)
            byte_cnt = 2'd3;
         else if (last_word && roll < 40)
            byte_cnt = 2'd1;
         else
            byte_cnt = 2'd2;
         // pseudo header fields only count on a first word
         if (first_word)
            send_word(mode, 1'b1, last_word, pick_half(), byte_cnt, src, dst, seg_len);
         else
            send_word(2'($urandom_range(3)), 1'b0, last_word, pick_half(), byte_cnt,
                      pick_addr(), pick_addr(), pick_half());
      end
   endtask

   // run limit
   initial begin
      #(8 * 400000);
      $display("FAILURE");
      $finish;
   end

   // stimulus and verdict
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // word with no first after reset: ipv4 sum, pseudo fields ignored
      send_word(MODE_TCP, 1'b0, 1'b1, 16'h1234, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF);
      // single-word ipv4 packets at both extremes
      send_word(MODE_IPV4, 1'b1, 1'b1, ALL_ONES, 2'd2, 32'h0, 32'h0, 16'h0);
      send_word(MODE_IPV4, 1'b1, 1'b1, ALL_ZEROS, 2'd2, 32'h0, 32'h0, 16'h0);
      // tcp with an all-ones pseudo header
      send_word(MODE_TCP, 1'b1, 1'b1, ALL_ONES, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF);
      // tcp sum of all ones: a zero checksum goes out unchanged
      send_word(MODE_TCP, 1'b1, 1'b1, 16'hFFF9, 2'd2, 32'h0, 32'h0, 16'h0);
      // udp sum of all ones: zero is replaced by all ones
      send_word(MODE_UDP, 1'b1, 1'b1, 16'hFFEE, 2'd2, 32'h0, 32'h0, 16'h0);
      // udp packet with a nonzero checksum field and an odd final byte
      send_word(MODE_UDP, 1'b1, 1'b0, 16'h1111, 2'd2, 32'hC0A8_0001, 32'h0A00_0002,
                16'h000D);
      send_word(MODE_UDP, 1'b0, 1'b0, 16'h2222, 2'd2, 32'h0, 32'h0, 16'h0);
      send_word(MODE_UDP, 1'b0, 1'b0, 16'h3333, 2'd2, 32'h0, 32'h0, 16'h0);
      send_word(MODE_UDP, 1'b0, 1'b0, 16'hABCD, 2'd2, 32'h0, 32'h0, 16'h0);
      send_word(MODE_UDP, 1'b0, 1'b1, 16'h12FF, 2'd1, 32'h0, 32'h0, 16'h0);
      // unused mode acts as ipv4
      send_word(MODE_UNUSED, 1'b1, 1'b1, 16'h8001, 2'd2, 32'h0A00_0001, 32'hC0A8_0001,
                16'h0014);
      // mode and pseudo fields on later words are ignored
      send_word(MODE_TCP, 1'b1, 1'b0, 16'h4500, 2'd2, 32'hC0A8_0001, 32'h0A00_0002,
                16'h0006);
      send_word(MODE_UDP, 1'b0, 1'b0, 16'h0001, 2'd2, 32'hFFFF_FFFF, 32'h1234_5678,
                16'hFFFF);
      send_word(MODE_IPV4, 1'b0, 1'b1, 16'hFF00, 2'd2, 32'h0, 32'hFFFF_FFFF, 16'h0);
      // byte counts 0 and 3 are full words, 1 pads even mid-packet
      send_word(MODE_IPV4, 1'b1, 1'b0, 16'hA5A5, 2'd0, 32'h0, 32'h0, 16'h0);
      send_word(MODE_IPV4, 1'b0, 1'b0, 16'h5AFF, 2'd1, 32'h0, 32'h0, 16'h0);
      send_word(MODE_IPV4, 1'b0, 1'b1, 16'hFFFF, 2'd3, 32'h0, 32'h0, 16'h0);
      // long udp packet runs the word position into saturation
      for (int i = 0; i < 9; i++)
         send_word(MODE_UDP, i == 0, i == 8, 16'(i) * 16'h1357, 2'd2, 32'h8000_0001,
                   32'h0000_FFFF, 16'h0012);

      // random packets under four pacing phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         while (words_sent < 27 + (phase + 1) * WORDS_PER_PHASE)
            send_random_packet();
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // drain, then let the pipeline settle
      while (pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d words, %0d packets closed; %0d checksums compared", words_sent,
               packets_closed, compared);
      $display("modes ipv4/tcp/udp/unused, broken framing, four sender/receiver pacings");
      if (mismatches == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
